FILE: hdl/sht_two_wire_sensor_master_unit_macros.svh
// Assertion macros shared by the sensor bus master.
`ifndef SHT_TWO_WIRE_SENSOR_MASTER_UNIT_MACROS_SVH
`define SHT_TWO_WIRE_SENSOR_MASTER_UNIT_MACROS_SVH

// Condition that must hold in the same cycle as its trigger.
`define SHT_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define SHT_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: hdl/sht_pkg.sv
// Types and codes shared by the sensor bus master.
`timescale 1ns / 1ps

package sht_pkg;

  localparam int unsigned CfgAddrW = 3;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_MEASURE = 2'd1,
    REQ_RESET   = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  // Register index of ticks_per_unit.
  localparam logic REG_TPU = 1'b0;

  // One result item of the sequencer.
  typedef struct packed {
    logic        sck_level;
    logic        data_drive;
    logic        data_level;
    logic        busy_res;
    logic        result_valid;
    logic [15:0] measured_word;
  } res_t;

endpackage

FILE: hdl/sht_cfg.sv
// APB-style configuration register holding the tick count per delay unit.
`timescale 1ns / 1ps

module sht_cfg
  import sht_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [7:0]          tpu_eff
);

  logic [7:0] tpu_r;
  logic       wr_en;
  logic       sel_tpu;

  assign pready  = 1'b1;
  assign sel_tpu = (paddr[2] == REG_TPU);
  assign wr_en   = psel && penable && pwrite && sel_tpu;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= 8'd1;
    end else if (wr_en) begin
      tpu_r <= pwdata[7:0];
    end
  end

  assign prdata = sel_tpu ? {24'd0, tpu_r} : 32'd0;

  // A programmed zero behaves like one tick per unit.
  assign tpu_eff = (tpu_r == 8'd0) ? 8'd1 : tpu_r;

endmodule

FILE: hdl/sht_seq.sv
// Bus sequencer: state registers and the next-step logic for one tick request.
`timescale 1ns / 1ps

module sht_seq
  import sht_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] req_type,
  input  logic [7:0] command,
  input  logic       data_pin,
  input  logic [7:0] tpu,
  output res_t       res
);

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_ST0        = 5'd1,
    PH_ST1        = 5'd2,
    PH_ST2        = 5'd3,
    PH_ST3        = 5'd4,
    PH_ST4        = 5'd5,
    PH_ST5        = 5'd6,
    PH_CMD_LEAD   = 5'd7,
    PH_CMD_SET    = 5'd8,
    PH_CMD_HIGH   = 5'd9,
    PH_ACK_WAIT   = 5'd10,
    PH_NINTH_LOW  = 5'd11,
    PH_NINTH_HIGH = 5'd12,
    PH_CONV_WAIT  = 5'd13,
    PH_RX_HIGH    = 5'd14,
    PH_RX_LOW     = 5'd15,
    PH_MACK_LEAD  = 5'd16,
    PH_MACK_HIGH  = 5'd17,
    PH_MACK_TAIL  = 5'd18,
    PH_RS_LOW     = 5'd19,
    PH_RS_HIGH    = 5'd20
  } phase_t;

  // Delay in 2 us units for each phase; zero means the phase waits for DATA low.
  function automatic logic [2:0] phase_units(input logic [4:0] ph);
    logic [2:0] u;
    unique case (ph)
      PH_ST0, PH_ST1, PH_ST2, PH_ST4, PH_ST5: u = 3'd1;
      PH_ST3: u = 3'd4;
      PH_CMD_LEAD, PH_CMD_SET, PH_CMD_HIGH, PH_NINTH_LOW, PH_NINTH_HIGH,
      PH_RX_HIGH, PH_RX_LOW, PH_MACK_LEAD, PH_MACK_HIGH, PH_MACK_TAIL,
      PH_RS_LOW, PH_RS_HIGH: u = 3'd2;
      default: u = 3'd0;
    endcase
    return u;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [3:0]  udc_r, udc_nxt;
  logic [7:0]  presc_r, presc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] rx_r, rx_nxt;
  logic        sck_r, sck_nxt;
  logic        drv_r, drv_nxt;
  logic        lvl_r, lvl_nxt;

  logic [2:0]  units;
  logic [7:0]  presc_inc;
  logic [3:0]  udc_inc;
  logic        fin;
  logic        valid;
  logic        go;
  phase_t      go_ph;

  always_comb begin
    cmd_nxt     = cmd_r;
    bit_cnt_nxt = bit_cnt_r;
    rx_nxt      = rx_r;
    sck_nxt     = sck_r;
    drv_nxt     = drv_r;
    lvl_nxt     = lvl_r;
    presc_nxt   = presc_r;
    udc_nxt     = udc_r;
    fin         = 1'b0;
    valid       = 1'b0;
    go          = 1'b0;
    go_ph       = phase_r;
    units       = phase_units(phase_r);
    presc_inc   = presc_r + 8'd1;
    udc_inc     = udc_r + 4'd1;

    if (phase_r == PH_IDLE) begin
      if (req_type == REQ_MEASURE) begin
        cmd_nxt     = command;
        bit_cnt_nxt = 4'd0;
        drv_nxt     = 1'b1;
        lvl_nxt     = 1'b1;
        go          = 1'b1;
        go_ph       = PH_ST0;
      end else if (req_type == REQ_RESET) begin
        bit_cnt_nxt = 4'd0;
        drv_nxt     = 1'b1;
        lvl_nxt     = 1'b1;
        go          = 1'b1;
        go_ph       = PH_RS_LOW;
      end
    end else if (units == 3'd0) begin
      fin = !data_pin;
    end else begin
      presc_nxt = presc_inc;
      if (presc_inc >= tpu) begin
        presc_nxt = 8'd0;
        udc_nxt   = udc_inc;
        if (udc_inc >= {1'b0, units}) begin
          fin = 1'b1;
          if (phase_r == PH_RX_HIGH) begin
            rx_nxt = {rx_r[14:0], data_pin};
          end
        end
      end
    end

    if (fin) begin
      go = 1'b1;
      unique case (phase_r)
        PH_ST0: begin sck_nxt = 1'b1; go_ph = PH_ST1; end
        PH_ST1: begin lvl_nxt = 1'b0; go_ph = PH_ST2; end
        PH_ST2: begin sck_nxt = 1'b0; go_ph = PH_ST3; end
        PH_ST3: begin sck_nxt = 1'b1; go_ph = PH_ST4; end
        PH_ST4: begin lvl_nxt = 1'b1; go_ph = PH_ST5; end
        PH_ST5: begin
          // The bit counter tells a measurement start from a reset start.
          sck_nxt = 1'b0;
          go_ph   = (bit_cnt_r == 4'd0) ? PH_CMD_LEAD : PH_IDLE;
        end
        PH_CMD_LEAD: begin
          drv_nxt     = 1'b1;
          lvl_nxt     = cmd_r[7];
          bit_cnt_nxt = 4'd0;
          go_ph       = PH_CMD_SET;
        end
        PH_CMD_SET: begin sck_nxt = 1'b1; go_ph = PH_CMD_HIGH; end
        PH_CMD_HIGH: begin
          sck_nxt = 1'b0;
          if (bit_cnt_r >= 4'd7) begin
            drv_nxt = 1'b0;
            lvl_nxt = 1'b1;
            go_ph   = PH_ACK_WAIT;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            cmd_nxt     = {cmd_r[6:0], 1'b0};
            lvl_nxt     = cmd_r[6];
            go_ph       = PH_CMD_SET;
          end
        end
        PH_ACK_WAIT:  go_ph = PH_NINTH_LOW;
        PH_NINTH_LOW: begin sck_nxt = 1'b1; go_ph = PH_NINTH_HIGH; end
        PH_NINTH_HIGH: begin
          sck_nxt = 1'b0;
          drv_nxt = 1'b0;
          lvl_nxt = 1'b1;
          go_ph   = PH_CONV_WAIT;
        end
        PH_CONV_WAIT: begin
          bit_cnt_nxt = 4'd0;
          sck_nxt     = 1'b1;
          go_ph       = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin sck_nxt = 1'b0; go_ph = PH_RX_LOW; end
        PH_RX_LOW: begin
          if (bit_cnt_r >= 4'd15) begin
            go_ph = PH_IDLE;
            valid = 1'b1;
          end else if (bit_cnt_r == 4'd7) begin
            // Master acknowledge after the high byte.
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            drv_nxt     = 1'b1;
            lvl_nxt     = 1'b0;
            go_ph       = PH_MACK_LEAD;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            sck_nxt     = 1'b1;
            go_ph       = PH_RX_HIGH;
          end
        end
        PH_MACK_LEAD: begin sck_nxt = 1'b1; go_ph = PH_MACK_HIGH; end
        PH_MACK_HIGH: begin sck_nxt = 1'b0; go_ph = PH_MACK_TAIL; end
        PH_MACK_TAIL: begin
          drv_nxt = 1'b0;
          lvl_nxt = 1'b1;
          sck_nxt = 1'b1;
          go_ph   = PH_RX_HIGH;
        end
        PH_RS_LOW: begin sck_nxt = 1'b1; go_ph = PH_RS_HIGH; end
        PH_RS_HIGH: begin
          sck_nxt = 1'b0;
          if (bit_cnt_r >= 4'd8) begin
            drv_nxt = 1'b1;
            lvl_nxt = 1'b1;
            go_ph   = PH_ST0;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            go_ph       = PH_RS_LOW;
          end
        end
        default: go_ph = PH_IDLE;
      endcase
    end

    phase_nxt = phase_r;
    if (go) begin
      phase_nxt = go_ph;
      udc_nxt   = 4'd0;
      presc_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= 4'd0;
      udc_r     <= 4'd0;
      presc_r   <= 8'd0;
      cmd_r     <= 8'd0;
      rx_r      <= 16'd0;
      sck_r     <= 1'b0;
      drv_r     <= 1'b0;
      lvl_r     <= 1'b1;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      udc_r     <= udc_nxt;
      presc_r   <= presc_nxt;
      cmd_r     <= cmd_nxt;
      rx_r      <= rx_nxt;
      sck_r     <= sck_nxt;
      drv_r     <= drv_nxt;
      lvl_r     <= lvl_nxt;
    end
  end

  assign res.sck_level     = sck_nxt;
  assign res.data_drive    = drv_nxt;
  assign res.data_level    = lvl_nxt;
  assign res.busy_res      = (phase_nxt != PH_IDLE);
  assign res.result_valid  = valid;
  assign res.measured_word = valid ? rx_nxt : 16'd0;

endmodule

FILE: hdl/sht_two_wire_sensor_master_unit.sv
// Top level of the two-wire humidity and temperature sensor bus master.
//
// Each input request is one bus tick: a plain tick, a measure request carrying
// the command byte, or a connection reset request. Every request yields exactly
// one result with the pin levels to drive (serial clock, DATA drive enable and
// level), a busy flag, and on completion of a measurement the 16-bit word with
// result_valid set.
// The result of an accepted request is registered and offered on the output
// channel in the cycle after it is accepted. Throughput is one request per cycle
// while the receiver takes results; the sequencer advances one step per accepted
// request and the result register lets the next request in while the current
// result is being taken.
// When the receiver stalls, the result stays in its register and in_ready goes
// low until it is taken; the sequencer does not move.
// A synchronous low rst_n returns the sequencer to idle with SCK low and DATA
// released, empties the result register and sets ticks_per_unit to one.
// ticks_per_unit is written over the APB-style port at byte address 0; the user
// must write it only while idle, which the block does not check; zero acts as one.
`timescale 1ns / 1ps

`include "sht_two_wire_sensor_master_unit_macros.svh"

module sht_two_wire_sensor_master_unit
  import sht_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_command,
  input  logic                in_data_pin,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_sck_level,
  output logic                out_data_drive,
  output logic                out_data_level,
  output logic                out_busy_res,
  output logic                out_result_valid,
  output logic [15:0]         out_measured_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0] tpu_eff;
  logic       accept;
  res_t       res;
  res_t       res_r;
  logic       out_valid_r;

  sht_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tpu_eff (tpu_eff)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  sht_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .req_type (in_req_type),
    .command  (in_command),
    .data_pin (in_data_pin),
    .tpu      (tpu_eff),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sck_level     = res_r.sck_level;
  assign out_data_drive    = res_r.data_drive;
  assign out_data_level    = res_r.data_level;
  assign out_busy_res      = res_r.busy_res;
  assign out_result_valid  = res_r.result_valid;
  assign out_measured_word = res_r.measured_word;

  `SHT_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted request gave no result")
  `SHT_ASSERT_SAME(a_done_not_busy, out_valid && out_result_valid, !out_busy_res, "busy on done")
  `SHT_ASSERT_SAME(a_word_zero, out_valid && !out_result_valid, out_measured_word == 16'd0, "word")

endmodule

FILE: tb/sv/sht_two_wire_sensor_master_unit_test.sv
// Self-checking testbench for the two-wire sensor bus master with a cycle-level bus predictor.
`timescale 1ns / 1ps

module sht_two_wire_sensor_master_unit_test;
  import sht_pkg::*;

  localparam int unsigned ITEMS = 1050;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [CfgAddrW-1:0] TPU_ADDR = CfgAddrW'(4 * int'(REG_TPU));

  typedef enum logic [1:0] {
    PIN_RANDOM,
    PIN_HIGH,
    PIN_LOW
  } pin_mode_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST0,
    PH_ST1,
    PH_ST2,
    PH_ST3,
    PH_ST4,
    PH_ST5,
    PH_CMD_LEAD,
    PH_CMD_SET,
    PH_CMD_HIGH,
    PH_ACK_WAIT,
    PH_NINTH_LOW,
    PH_NINTH_HIGH,
    PH_CONV_WAIT,
    PH_RX_HIGH,
    PH_RX_LOW,
    PH_MACK_LEAD,
    PH_MACK_HIGH,
    PH_MACK_TAIL,
    PH_RS_LOW,
    PH_RS_HIGH
  } phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_req_type = REQ_TICK;
  logic [7:0]          in_command = 8'h00;
  logic                in_data_pin = 1'b1;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_sck_level;
  logic                out_data_drive;
  logic                out_data_level;
  logic                out_busy_res;
  logic                out_result_valid;
  logic [15:0]         out_measured_word;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  sht_two_wire_sensor_master_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_command       (in_command),
    .in_data_pin      (in_data_pin),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sck_level    (out_sck_level),
    .out_data_drive   (out_data_drive),
    .out_data_level   (out_data_level),
    .out_busy_res     (out_busy_res),
    .out_result_valid (out_result_valid),
    .out_measured_word(out_measured_word),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // Predicted sequencer state and configuration.
  phase_t      seq_phase = PH_IDLE;
  logic [3:0]  bit_cnt = '0;
  logic [3:0]  unit_cnt = '0;
  logic [7:0]  presc = '0;
  logic [7:0]  cmd_sh = '0;
  logic [15:0] rx_sh = '0;
  logic        sck_q = 1'b0;
  logic        drv_q = 1'b0;
  logic        lvl_q = 1'b1;
  logic [7:0]  cfg_tpu = 8'd1;

  res_t pending_bus_results[$];
  int   errors = 0;
  int   sent_items = 0;
  int   hold_count = 0;
  int   stall_cycles = 0;
  bit   idle_off = 1'b0;
  bit   rx_hold_req = 1'b0;

  function automatic void enter_phase(input phase_t p);
    seq_phase = p;
    unit_cnt = '0;
    presc = '0;
  endfunction

  function automatic void release_bus();
    drv_q = 1'b0;
    lvl_q = 1'b1;
  endfunction

  function automatic int unsigned delay_units(input phase_t p);
    case (p)
      PH_IDLE, PH_ACK_WAIT, PH_CONV_WAIT: return 0;
      PH_ST3: return 4;
      PH_ST0, PH_ST1, PH_ST2, PH_ST4, PH_ST5: return 1;
      default: return 2;
    endcase
  endfunction

  // Pin actions that close the current phase; returns 1 when the word is complete.
  function automatic bit end_of_step();
    bit done;
    done = 1'b0;
    case (seq_phase)
      PH_ST0: begin sck_q = 1'b1; enter_phase(PH_ST1); end
      PH_ST1: begin lvl_q = 1'b0; enter_phase(PH_ST2); end
      PH_ST2: begin sck_q = 1'b0; enter_phase(PH_ST3); end
      PH_ST3: begin sck_q = 1'b1; enter_phase(PH_ST4); end
      PH_ST4: begin lvl_q = 1'b1; enter_phase(PH_ST5); end
      PH_ST5: begin
        sck_q = 1'b0;
        // A measurement continues with the command; a connection reset ends here.
        if (bit_cnt == 4'd0) begin
          enter_phase(PH_CMD_LEAD);
        end else begin
          enter_phase(PH_IDLE);
        end
      end
      PH_CMD_LEAD: begin
        drv_q = 1'b1;
        lvl_q = cmd_sh[7];
        bit_cnt = '0;
        enter_phase(PH_CMD_SET);
      end
      PH_CMD_SET: begin sck_q = 1'b1; enter_phase(PH_CMD_HIGH); end
      PH_CMD_HIGH: begin
        sck_q = 1'b0;
        if (bit_cnt >= 4'd7) begin
          release_bus();
          enter_phase(PH_ACK_WAIT);
        end else begin
          bit_cnt = bit_cnt + 4'd1;
          cmd_sh = cmd_sh << 1;
          lvl_q = cmd_sh[7];
          enter_phase(PH_CMD_SET);
        end
      end
      PH_ACK_WAIT: enter_phase(PH_NINTH_LOW);
      PH_NINTH_LOW: begin sck_q = 1'b1; enter_phase(PH_NINTH_HIGH); end
      PH_NINTH_HIGH: begin
        sck_q = 1'b0;
        release_bus();
        enter_phase(PH_CONV_WAIT);
      end
      PH_CONV_WAIT: begin
        bit_cnt = '0;
        sck_q = 1'b1;
        enter_phase(PH_RX_HIGH);
      end
      PH_RX_HIGH: begin sck_q = 1'b0; enter_phase(PH_RX_LOW); end
      PH_RX_LOW: begin
        if (bit_cnt >= 4'd15) begin
          enter_phase(PH_IDLE);
          done = 1'b1;
        end else if (bit_cnt == 4'd7) begin
          // Master acknowledge between the high and the low byte.
          bit_cnt = bit_cnt + 4'd1;
          drv_q = 1'b1;
          lvl_q = 1'b0;
          enter_phase(PH_MACK_LEAD);
        end else begin
          bit_cnt = bit_cnt + 4'd1;
          sck_q = 1'b1;
          enter_phase(PH_RX_HIGH);
        end
      end
      PH_MACK_LEAD: begin sck_q = 1'b1; enter_phase(PH_MACK_HIGH); end
      PH_MACK_HIGH: begin sck_q = 1'b0; enter_phase(PH_MACK_TAIL); end
      PH_MACK_TAIL: begin
        release_bus();
        sck_q = 1'b1;
        enter_phase(PH_RX_HIGH);
      end
      PH_RS_LOW: begin sck_q = 1'b1; enter_phase(PH_RS_HIGH); end
      PH_RS_HIGH: begin
        sck_q = 1'b0;
        if (bit_cnt >= 4'd8) begin
          drv_q = 1'b1;
          lvl_q = 1'b1;
          enter_phase(PH_ST0);
        end else begin
          bit_cnt = bit_cnt + 4'd1;
          enter_phase(PH_RS_LOW);
        end
      end
      default: enter_phase(PH_IDLE);
    endcase
    return done;
  endfunction

  function automatic res_t predict_bus_step(input logic [1:0] req, input logic [7:0] cmd,
                                            input logic pin);
    res_t        r;
    bit          done;
    int unsigned units;
    logic [7:0]  tpu;
    done = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (req == REQ_MEASURE) begin
        cmd_sh = cmd;
        bit_cnt = '0;
        drv_q = 1'b1;
        lvl_q = 1'b1;
        enter_phase(PH_ST0);
      end else if (req == REQ_RESET) begin
        bit_cnt = '0;
        drv_q = 1'b1;
        lvl_q = 1'b1;
        enter_phase(PH_RS_LOW);
      end
    end else begin
      // While busy every request type counts as a plain tick.
      units = delay_units(seq_phase);
      if (units == 0) begin
        if (pin == 1'b0) begin
          done = end_of_step();
        end
      end else begin
        tpu = (cfg_tpu == 8'd0) ? 8'd1 : cfg_tpu;
        presc = presc + 8'd1;
        if (presc >= tpu) begin
          presc = '0;
          unit_cnt = unit_cnt + 4'd1;
          if (unit_cnt >= units) begin
            if (seq_phase == PH_RX_HIGH) begin
              rx_sh = {rx_sh[14:0], pin};
            end
            done = end_of_step();
          end
        end
      end
    end
    r.sck_level = sck_q;
    r.data_drive = drv_q;
    r.data_level = lvl_q;
    r.busy_res = (seq_phase != PH_IDLE);
    r.result_valid = done;
    r.measured_word = done ? rx_sh : 16'h0000;
    return r;
  endfunction

  function automatic string fmt_result(input res_t r);
    return $sformatf("sck=%0b drv=%0b lvl=%0b busy=%0b valid=%0b word=%04h",
                     r.sck_level, r.data_drive, r.data_level, r.busy_res,
                     r.result_valid, r.measured_word);
  endfunction

  task automatic report_mismatch(input string what, input string want, input string got);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s: expected %s, got %s", $realtime, what, want, got);
    end
  endtask

  // Sends one request and records the result it should produce.
  task automatic send_item(input logic [1:0] req, input logic [7:0] cmd, input logic pin);
    while (!idle_off && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_command <= cmd;
    in_data_pin <= pin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_bus_results.push_back(predict_bus_step(req, cmd, pin));
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bus_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_tpu(input logic [7:0] value);
    logic [31:0] rd;
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TPU_ADDR;
    pwdata <= {24'h000000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_tpu = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {24'h000000, value}) begin
      report_mismatch("ticks_per_unit read", $sformatf("%08h", {24'h0, value}),
                      $sformatf("%08h", rd));
    end
  endtask

  function automatic logic pick_pin(input pin_mode_t mode);
    if (mode == PIN_LOW) begin
      return 1'b0;
    end
    // Hold DATA high for a few ticks so the sensor waits take some time.
    if (seq_phase == PH_ACK_WAIT || seq_phase == PH_CONV_WAIT) begin
      return ($urandom_range(99) < 30) ? 1'b0 : 1'b1;
    end
    if (mode == PIN_HIGH) begin
      return 1'b1;
    end
    return 1'($urandom);
  endfunction

  task automatic finish_sequence(input pin_mode_t mode, input int noise_pct);
    logic [1:0] req;
    while (seq_phase != PH_IDLE) begin
      req = REQ_TICK;
      if ($urandom_range(99) < noise_pct) begin
        req = 2'($urandom_range(3, 1));
      end
      send_item(req, 8'($urandom), pick_pin(mode));
    end
  endtask

  task automatic run_sequence(input logic [1:0] req, input logic [7:0] cmd,
                              input pin_mode_t mode, input int noise_pct);
    send_item(req, cmd, 1'($urandom));
    finish_sequence(mode, noise_pct);
  endtask

  task automatic test_idle_requests();
    send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_TICK, 8'hFF, 1'b1);
    send_item(REQ_UNUSED, 8'hFF, 1'b0);
    send_item(REQ_UNUSED, 8'h00, 1'b1);
  endtask

  task automatic test_connection_reset();
    send_item(REQ_RESET, 8'h5A, 1'b1);
    // New requests while busy must be ignored.
    send_item(REQ_MEASURE, 8'hFF, 1'b0);
    send_item(REQ_RESET, 8'h00, 1'b1);
    send_item(REQ_UNUSED, 8'hA5, 1'b0);
    finish_sequence(PIN_RANDOM, 0);
  endtask

  task automatic test_measure_extremes();
    run_sequence(REQ_MEASURE, 8'hFF, PIN_HIGH, 0);
    run_sequence(REQ_MEASURE, 8'h00, PIN_LOW, 0);
  endtask

  task automatic test_timing_settings();
    write_tpu(8'd0);
    run_sequence(REQ_RESET, 8'($urandom), PIN_RANDOM, 5);
    // At the slowest setting only the first start step is timed; the rest runs fast.
    write_tpu(8'd255);
    send_item(REQ_MEASURE, 8'($urandom), 1'($urandom));
    while (seq_phase == PH_ST0) begin
      send_item(REQ_TICK, 8'($urandom), 1'($urandom));
    end
    write_tpu(8'd1);
    finish_sequence(PIN_RANDOM, 5);
  endtask

  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    run_sequence(REQ_RESET, 8'($urandom), PIN_RANDOM, 5);
    rx_hold_req = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int         round;
    int         pick;
    logic [7:0] tpu;
    pin_mode_t  mode;
    round = 0;
    while (sent_items < ITEMS) begin
      pick = $urandom_range(9);
      tpu = (pick <= 6) ? 8'd1 : (pick <= 8) ? 8'd2 : 8'd0;
      write_tpu(tpu);
      // The first round runs with no idle cycles on either side.
      idle_off = (round == 0);
      repeat ($urandom_range(3, 0)) begin
        send_item($urandom_range(1) ? REQ_TICK : REQ_UNUSED, 8'($urandom), 1'($urandom));
      end
      pick = $urandom_range(9);
      mode = (pick == 0) ? PIN_HIGH : (pick == 1) ? PIN_LOW : PIN_RANDOM;
      run_sequence(($urandom_range(3) == 0) ? REQ_RESET : REQ_MEASURE, 8'($urandom),
                   mode, 8);
      round++;
    end
    idle_off = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rx_hold_req && hold_count < RX_HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (!rx_hold_req) begin
        hold_count <= 0;
      end
      out_ready <= idle_off || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin : check_results
    res_t seen;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_sck_level, out_data_drive, out_data_level, out_busy_res,
              out_result_valid, out_measured_word};
      if (pending_bus_results.size() == 0) begin
        report_mismatch("unexpected result", "none", fmt_result(seen));
      end else begin
        want = pending_bus_results.pop_front();
        if (seen !== want) begin
          report_mismatch("result", fmt_result(want), fmt_result(seen));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_requests();
    test_connection_reset();
    test_measure_extremes();
    test_timing_settings();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_bus_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sht_pkg.sv
hdl/sht_cfg.sv
hdl/sht_seq.sv
hdl/sht_two_wire_sensor_master_unit.sv
tb/sv/sht_two_wire_sensor_master_unit_test.sv
